### sv/mne_pkg.sv
// Shared types, constants and keypad group tables for the multi-tap name editor.
// No dependencies; imported by every module of the block.
`default_nettype none

package mne_pkg;

   localparam int NAME_LENGTH_DEFAULT = 8;
   localparam int NUM_GROUP_KEYS      = 13;

   localparam logic [7:0] SPACE_CHAR        = 8'h20;
   localparam logic [7:0] TAP_TIMEOUT_RESET = 8'd2;

   localparam int CMD_W = 3;
   localparam int KEY_W = 4;
   localparam int POS_W = 5;
   localparam int CHR_W = 8;

   // Register word index taken from the byte address
   localparam logic REG_TAP_TIMEOUT = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 3'd0,
      CMD_KEY    = 3'd1,
      CMD_LEFT   = 3'd2,
      CMD_RIGHT  = 3'd3,
      CMD_DELETE = 3'd4,
      CMD_LOAD   = 3'd5,
      CMD_SAVE   = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPORT,
      ST_SAVE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic latch;
      logic exec;
      logic report;
      logic save_emit;
   } mne_ctl_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_save;
      logic save_last;
   } mne_sts_type;

   function automatic logic [CHR_W-1:0] group_first(input logic [KEY_W-1:0] key);
      logic [CHR_W-1:0] c;
      case (key)
         4'd0:    c = "A";
         4'd1:    c = "D";
         4'd2:    c = "G";
         4'd3:    c = "J";
         4'd4:    c = "M";
         4'd5:    c = "P";
         4'd6:    c = "S";
         4'd7:    c = "V";
         4'd8:    c = "Y";
         4'd9:    c = "0";
         4'd10:   c = "1";
         4'd11:   c = "4";
         4'd12:   c = "7";
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] group_len(input logic [KEY_W-1:0] key);
      logic [1:0] n;
      case (key)
         4'd8:    n = 2'd2;
         4'd9:    n = 2'd1;
         default: n = 2'd3;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

### sv/mne_ctrl.sv
// Sequencing state machine for the multi-tap name editor.
// Depends on mne_pkg for the state enum and the command/status structs.
`default_nettype none

module mne_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   output mne_pkg::mne_ctl_type     ctl,
   input  wire mne_pkg::mne_sts_type sts
);
   import mne_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      ctl           = '0;
      busy          = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = sts.is_save ? ST_SAVE : ST_REPORT;
         end
         ST_REPORT: begin
            ctl.report = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SAVE: begin
            ctl.save_emit = 1'b1;
            if (sts.save_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/mne_datapath.sv
// Datapath of the multi-tap name editor: name buffer, cursor, tap state, result registers.
// Depends on mne_pkg for command codes, group tables and the control structs.
`default_nettype none

module mne_datapath #(
   parameter int NAME_LENGTH = mne_pkg::NAME_LENGTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mne_pkg::mne_ctl_type       ctl,
   output mne_pkg::mne_sts_type            sts,
   input  wire logic [7:0]                 tap_timeout,
   input  wire logic [mne_pkg::CMD_W-1:0]  req_cmd,
   input  wire logic [mne_pkg::KEY_W-1:0]  req_key,
   input  wire logic [mne_pkg::POS_W-1:0]  req_position,
   input  wire logic [mne_pkg::CHR_W-1:0]  req_load_value,
   output logic                            rsp_valid,
   output logic [mne_pkg::POS_W-1:0]       rsp_cursor,
   output logic [mne_pkg::POS_W-1:0]       rsp_char_index,
   output logic [mne_pkg::CHR_W-1:0]       rsp_char_value,
   output logic                            rsp_tap_pending,
   output logic                            rsp_last
);
   import mne_pkg::*;

   localparam int IDX_W = (NAME_LENGTH > 1) ? $clog2(NAME_LENGTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NAME_LENGTH - 1);
   localparam logic [POS_W:0]   LEN_EXT  = (POS_W + 1)'(NAME_LENGTH);

   // Latched command fields
   cmd_type          cmd_ff;
   logic [KEY_W-1:0] key_ff;
   logic [POS_W-1:0] pos_ff;
   logic [CHR_W-1:0] val_ff;

   // Editor state
   logic [CHR_W-1:0] store_ff [NAME_LENGTH];
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic [7:0]       countdown_ff, countdown_in;
   logic [KEY_W-1:0] prev_key_ff, prev_key_in;
   logic [CHR_W-1:0] group_base_ff, group_base_in;
   logic [1:0]       group_size_ff, group_size_in;
   logic [1:0]       group_offset_ff, group_offset_in;
   logic [IDX_W-1:0] save_idx_ff, save_idx_in;

   // Result registers
   logic             rsp_valid_ff;
   logic [POS_W-1:0] rsp_cursor_ff, rsp_char_index_ff;
   logic [CHR_W-1:0] rsp_char_value_ff;
   logic             rsp_tap_pending_ff, rsp_last_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [CHR_W-1:0] wr_data;
   logic [IDX_W-1:0] cursor_adv;
   logic [IDX_W-1:0] rd_addr;
   logic             pos_ok;
   logic [1:0]       offset_next;

   assign pos_ok     = {1'b0, pos_ff} < LEN_EXT;
   assign cursor_adv = (cursor_ff == LAST_IDX) ? cursor_ff : cursor_ff + 1'b1;
   assign offset_next = (({1'b0, group_offset_ff} + 3'd1) >= {1'b0, group_size_ff}) ?
                        2'd0 : group_offset_ff + 2'd1;

   assign sts.is_save   = (cmd_ff == CMD_SAVE);
   assign sts.save_last = (save_idx_ff == LAST_IDX);

   // State update for the latched command
   always_comb begin
      cursor_in       = cursor_ff;
      countdown_in    = countdown_ff;
      prev_key_in     = prev_key_ff;
      group_base_in   = group_base_ff;
      group_size_in   = group_size_ff;
      group_offset_in = group_offset_ff;
      wr_en           = 1'b0;
      wr_addr         = cursor_ff;
      wr_data         = SPACE_CHAR;
      if (ctl.exec) begin
         case (cmd_ff)
            CMD_TICK: begin
               if (countdown_ff != 8'd0) begin
                  countdown_in = countdown_ff - 8'd1;
                  if (countdown_ff == 8'd1) begin
                     cursor_in = cursor_adv;
                  end
               end
            end
            CMD_KEY: begin
               if (key_ff < KEY_W'(NUM_GROUP_KEYS)) begin
                  wr_en = 1'b1;
                  if (countdown_ff != 8'd0 && key_ff == prev_key_ff) begin
                     group_offset_in = offset_next;
                     wr_data         = group_base_ff + CHR_W'(offset_next);
                  end else begin
                     // a different key closes the pending tap one place right
                     if (countdown_ff != 8'd0) begin
                        cursor_in = cursor_adv;
                        wr_addr   = cursor_adv;
                     end
                     group_base_in   = group_first(key_ff);
                     group_size_in   = group_len(key_ff);
                     group_offset_in = 2'd0;
                     wr_data         = group_first(key_ff);
                  end
                  prev_key_in  = key_ff;
                  countdown_in = tap_timeout;
               end
            end
            CMD_LEFT: begin
               countdown_in = 8'd0;
               cursor_in    = (cursor_ff == '0) ? cursor_ff : cursor_ff - 1'b1;
            end
            CMD_RIGHT: begin
               countdown_in = 8'd0;
               cursor_in    = cursor_adv;
            end
            CMD_DELETE: begin
               wr_en = 1'b1;
            end
            CMD_LOAD: begin
               wr_en   = pos_ok;
               wr_addr = pos_ff[IDX_W-1:0];
               wr_data = val_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign save_idx_in = ctl.exec ? '0 :
                        (ctl.save_emit ? save_idx_ff + 1'b1 : save_idx_ff);

   assign rd_addr = ctl.save_emit ? save_idx_ff :
                    ((cmd_ff == CMD_LOAD) ? pos_ff[IDX_W-1:0] : cursor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NAME_LENGTH; i++) begin
            store_ff[i] <= SPACE_CHAR;
         end
      end else if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff       <= '0;
         countdown_ff    <= '0;
         prev_key_ff     <= '0;
         group_base_ff   <= '0;
         group_size_ff   <= '0;
         group_offset_ff <= '0;
         save_idx_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cursor_ff       <= cursor_in;
         countdown_ff    <= countdown_in;
         prev_key_ff     <= prev_key_in;
         group_base_ff   <= group_base_in;
         group_size_ff   <= group_size_in;
         group_offset_ff <= group_offset_in;
         save_idx_ff     <= save_idx_in;
         rsp_valid_ff    <= ctl.report | ctl.save_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= cmd_type'(req_cmd);
         key_ff <= req_key;
         pos_ff <= req_position;
         val_ff <= req_load_value;
      end
      if (ctl.report || ctl.save_emit) begin
         rsp_cursor_ff      <= POS_W'(cursor_ff);
         rsp_tap_pending_ff <= (countdown_ff != 8'd0);
         if (ctl.save_emit) begin
            rsp_char_index_ff <= POS_W'(save_idx_ff);
            rsp_char_value_ff <= store_ff[rd_addr];
            rsp_last_ff       <= (save_idx_ff == LAST_IDX);
         end else if (cmd_ff == CMD_LOAD) begin
            rsp_char_index_ff <= pos_ff;
            rsp_char_value_ff <= pos_ok ? store_ff[rd_addr] : '0;
            rsp_last_ff       <= 1'b1;
         end else begin
            rsp_char_index_ff <= POS_W'(cursor_ff);
            rsp_char_value_ff <= store_ff[rd_addr];
            rsp_last_ff       <= 1'b1;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cursor      = rsp_cursor_ff;
   assign rsp_char_index  = rsp_char_index_ff;
   assign rsp_char_value  = rsp_char_value_ff;
   assign rsp_tap_pending = rsp_tap_pending_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

### sv/multitap_name_editor.sv
// A result strobe follows the accepting edge through the execute state, the report state and the result registers.
// A new command is taken only once the last one is executed and reported (execute, then registered buffer read);
// save streams NAME_LENGTH results on consecutive cycles before the next command is taken.
// The receiver cannot stall: rsp_valid is a single-cycle strobe per result.
// Reset (synchronous, high): name buffer to spaces, cursor/tap state to zero, timeout to 2.
// Top level: APB register, controller and datapath; depends on mne_pkg.
`default_nettype none

module multitap_name_editor #(
   parameter int NAME_LENGTH = mne_pkg::NAME_LENGTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // command channel
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [mne_pkg::CMD_W-1:0]  req_cmd,
   input  wire logic [mne_pkg::KEY_W-1:0]  req_key,
   input  wire logic [mne_pkg::POS_W-1:0]  req_position,
   input  wire logic [mne_pkg::CHR_W-1:0]  req_load_value,
   // result channel
   output logic                            rsp_valid,
   output logic [mne_pkg::POS_W-1:0]       rsp_cursor,
   output logic [mne_pkg::POS_W-1:0]       rsp_char_index,
   output logic [mne_pkg::CHR_W-1:0]       rsp_char_value,
   output logic                            rsp_tap_pending,
   output logic                            rsp_last,
   // register port
   input  wire logic                       psel,
   input  wire logic                       penable,
   input  wire logic                       pwrite,
   input  wire logic [2:0]                 paddr,
   input  wire logic [31:0]                pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import mne_pkg::*;

   mne_ctl_type ctl;
   mne_sts_type sts;

   logic [7:0] tap_timeout_ff;
   logic       csr_wr;

   // Single register: word index is paddr[2]; byte offset bits are ignored.
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready & (paddr[2] == REG_TAP_TIMEOUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_timeout_ff <= TAP_TIMEOUT_RESET;
      end else if (csr_wr) begin
         tap_timeout_ff <= pwdata[7:0];
      end
   end

   // Reads of the unused word return zero
   assign prdata = (paddr[2] == REG_TAP_TIMEOUT) ? {24'd0, tap_timeout_ff} : 32'd0;

   // Controller: accept when idle, execute, then report or stream the buffer
   mne_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .ctl   (ctl),
      .sts   (sts)
   );

   // Datapath: hold the name buffer and tap state, drive the result registers
   mne_datapath #(
      .NAME_LENGTH (NAME_LENGTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .tap_timeout     (tap_timeout_ff),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_position    (req_position),
      .req_load_value  (req_load_value),
      .rsp_valid       (rsp_valid),
      .rsp_cursor      (rsp_cursor),
      .rsp_char_index  (rsp_char_index),
      .rsp_char_value  (rsp_char_value),
      .rsp_tap_pending (rsp_tap_pending),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

### sim/multitap_name_editor_test.sv
// Self-checking test of the multi-tap name editor: commands in, reports compared in order.
// Holds its own model of the name buffer, cursor and tap timer.
// Depends on mne_pkg and multitap_name_editor; needs no other file.
`default_nettype none

module multitap_name_editor_test;
   import mne_pkg::*;

   localparam int NLEN = NAME_LENGTH_DEFAULT;
   // give up long after the slowest legal run would have ended
   localparam int CYCLE_LIMIT = 100000;
   // cmd code 7 has no enum member: the block must treat it as a no-op
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam logic [2:0] TIMEOUT_ADDR = {REG_TAP_TIMEOUT, 2'b00};

   // first character and length of each key's letter group
   localparam logic [CHR_W-1:0] GROUP_FIRST [NUM_GROUP_KEYS] =
      '{"A", "D", "G", "J", "M", "P", "S", "V", "Y", "0", "1", "4", "7"};
   localparam int GROUP_SIZE [NUM_GROUP_KEYS] = '{3, 3, 3, 3, 3, 3, 3, 3, 2, 1, 3, 3, 3};

   typedef struct packed {
      logic [POS_W-1:0] cursor;
      logic [POS_W-1:0] index;
      logic [CHR_W-1:0] value;
      logic             pending;
      logic             last;
   } name_report_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [CMD_W-1:0]  req_cmd;
   logic [KEY_W-1:0]  req_key;
   logic [POS_W-1:0]  req_position;
   logic [CHR_W-1:0]  req_load_value;
   logic              rsp_valid;
   logic [POS_W-1:0]  rsp_cursor;
   logic [POS_W-1:0]  rsp_char_index;
   logic [CHR_W-1:0]  rsp_char_value;
   logic              rsp_tap_pending;
   logic              rsp_last;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [2:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   // model state of the editor
   logic [CHR_W-1:0]  name_buf [NLEN];
   int                cursor_m;
   logic [7:0]        countdown_m;
   logic [7:0]        timeout_m;
   logic [KEY_W-1:0]  prev_key_m;
   logic [CHR_W-1:0]  group_base_m;
   int                group_size_m;
   int                group_off_m;

   // reports the block still owes, oldest first
   name_report_type   name_reports [$];
   int                fails = 0;
   int                cycles = 0;
   int                burst_left = 0;

   multitap_name_editor #(.NAME_LENGTH(NLEN)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .req_position    (req_position),
      .req_load_value  (req_load_value),
      .rsp_valid       (rsp_valid),
      .rsp_cursor      (rsp_cursor),
      .rsp_char_index  (rsp_char_index),
      .rsp_char_value  (rsp_char_value),
      .rsp_tap_pending (rsp_tap_pending),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost report ends the run here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   // Move the cursor, clamp it to the buffer and drop any pending tap.
   function automatic void step_cursor(input int delta);
      int next;
      next = cursor_m + delta;
      countdown_m = '0;
      if (next < 0) next = 0;
      if (next > NLEN - 1) next = NLEN - 1;
      cursor_m = next;
   endfunction

   // Advance to the next letter of the group, wrapping round, and write it.
   function automatic void next_in_group();
      group_off_m++;
      if (group_off_m >= group_size_m) group_off_m = 0;
      name_buf[cursor_m] = group_base_m + CHR_W'(group_off_m);
   endfunction

   function automatic void queue_report(input int idx, input logic [CHR_W-1:0] val,
                                        input logic fin);
      name_reports.push_back('{cursor: POS_W'(cursor_m), index: POS_W'(idx), value: val,
                               pending: (countdown_m != 0), last: fin});
   endfunction

   // Apply one accepted command to the model and queue the reports it causes.
   function automatic void enter_command(input logic [CMD_W-1:0] cmd,
                                         input logic [KEY_W-1:0] key,
                                         input logic [POS_W-1:0] pos,
                                         input logic [CHR_W-1:0] val);
      case (cmd)
         CMD_TICK: begin
            if (countdown_m != 0) begin
               countdown_m--;
               // timer ran out: the letter is committed and the cursor steps on
               if (countdown_m == 0) step_cursor(1);
            end
         end
         CMD_KEY: begin
            // keys past the last group are dropped without touching state
            if (key < NUM_GROUP_KEYS) begin
               if (countdown_m != 0 && key == prev_key_m) begin
                  next_in_group();
               end else begin
                  // a different key while a tap is pending commits the letter first
                  if (countdown_m != 0) step_cursor(1);
                  group_base_m = GROUP_FIRST[key];
                  group_size_m = GROUP_SIZE[key];
                  group_off_m  = group_size_m;
                  next_in_group();
               end
               prev_key_m  = key;
               countdown_m = timeout_m;
            end
         end
         CMD_LEFT:   step_cursor(-1);
         CMD_RIGHT:  step_cursor(1);
         CMD_DELETE: name_buf[cursor_m] = SPACE_CHAR;
         CMD_LOAD: begin
            // positions past the buffer write nothing and report a zero character
            if (pos < NLEN) begin
               name_buf[pos] = val;
               queue_report(int'(pos), val, 1'b1);
            end else begin
               queue_report(int'(pos), '0, 1'b1);
            end
            return;
         end
         CMD_SAVE: begin
            for (int i = 0; i < NLEN; i++) queue_report(i, name_buf[i], i == NLEN - 1);
            return;
         end
         default: ;
      endcase
      queue_report(cursor_m, name_buf[cursor_m], 1'b1);
   endfunction

   // -------------------------------------------------------------- checker

   function automatic int field_mismatch(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
      if (want === got) return 0;
      $error("%s expected %0h got %0h", field, want, got);
      return 1;
   endfunction

   // Every strobe is a report; pair it with the oldest one still owed.
   always @(posedge clock) begin : check_reports
      name_report_type due;
      if (!reset && rsp_valid === 1'b1) begin
         if (name_reports.size() == 0) begin
            $error("report with nothing outstanding: index %0d value %0h",
                   rsp_char_index, rsp_char_value);
            fails++;
         end else begin
            due = name_reports.pop_front();
            fails += field_mismatch("cursor", 8'(due.cursor), 8'(rsp_cursor));
            fails += field_mismatch("char_index", 8'(due.index), 8'(rsp_char_index));
            fails += field_mismatch("char_value", due.value, rsp_char_value);
            fails += field_mismatch("tap_pending", 8'(due.pending), 8'(rsp_tap_pending));
            fails += field_mismatch("last", 8'(due.last), 8'(rsp_last));
         end
      end
   end

   // --------------------------------------------------------------- driving

   // Send one command: bursts of back-to-back transactions with random gaps
   // between them. Returns at the edge that accepts it.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                               input logic [POS_W-1:0] pos, input logic [CHR_W-1:0] val);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
         // now and then a long run without any gap
         burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 6);
      end
      burst_left--;
      start          = 1'b1;
      req_cmd        = cmd;
      req_key        = key;
      req_position   = pos;
      req_load_value = val;
      do @(posedge clock); while (busy !== 1'b0);
      enter_command(cmd, key, pos, val);
   endtask

   // Drop start, then hold until every owed report is in and the block is idle.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      burst_left = 0;
      while (name_reports.size() != 0 || busy !== 1'b0) @(posedge clock);
      // leave margin for anything still in flight
      repeat (6) @(posedge clock);
   endtask

   // Write tap_timeout while idle and read it back.
   task automatic write_timeout(input logic [7:0] value);
      drain();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = TIMEOUT_ADDR;
      pwdata  = {24'd0, value};
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      timeout_m = value;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== {24'd0, value}) begin
         $error("tap_timeout readback expected %0h got %0h", value, prdata);
         fails++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // ----------------------------------------------------------------- tests

   // Save straight after reset shows an all-space name; left clamps at zero.
   task automatic test_reset_state();
      send_command(CMD_SAVE, '0, '0, '0);
      send_command(CMD_LEFT, '0, '0, '0);
   endtask

   // Cycle a group past its end, switch keys mid-tap, let the timer expire.
   task automatic test_multitap();
      repeat (4) send_command(CMD_KEY, 4'd0, '0, '0);
      // single-letter group, entered by a different key while a tap is pending
      repeat (2) send_command(CMD_KEY, 4'd9, '0, '0);
      repeat (2) send_command(CMD_TICK, '0, '0, '0);
   endtask

   // Ignored key, delete under a pending tap, unused code, right clamp, loads.
   task automatic test_editing();
      send_command(CMD_KEY, 4'd15, '0, '0);
      send_command(CMD_KEY, 4'd8, '0, '0);
      send_command(CMD_DELETE, '0, '0, '0);
      send_command(CMD_UNUSED, '0, '0, '0);
      repeat (6) send_command(CMD_RIGHT, '0, '0, '0);
      send_command(CMD_LOAD, '0, 5'(NLEN - 1), 8'hFF);
      send_command(CMD_LOAD, '0, 5'd31, 8'h00);
      send_command(CMD_SAVE, '0, '0, '0);
   endtask

   // With no timeout every press starts its group afresh at the cursor.
   task automatic test_zero_timeout();
      write_timeout(8'd0);
      repeat (2) send_command(CMD_KEY, 4'd3, '0, '0);
      send_command(CMD_KEY, 4'd12, '0, '0);
   endtask

   // Mostly key runs and ticks so words get spelled; the rest is noise.
   task automatic test_random_editing(input int count, input logic [7:0] timeout);
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
      logic [POS_W-1:0] pos;
      int               pick;
      write_timeout(timeout);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         key  = KEY_W'($urandom_range(0, 15));
         pos  = POS_W'($urandom_range(0, 31));
         if (pick < 40) begin
            cmd = CMD_KEY;
            if ($urandom_range(0, 1) == 1) key = prev_key_m;
            else if ($urandom_range(0, 9) != 0) key = KEY_W'($urandom_range(0, NUM_GROUP_KEYS - 1));
         end else if (pick < 65) begin
            cmd = CMD_TICK;
         end else if (pick < 72) begin
            cmd = CMD_LEFT;
         end else if (pick < 80) begin
            cmd = CMD_RIGHT;
         end else if (pick < 85) begin
            cmd = CMD_DELETE;
         end else if (pick < 94) begin
            cmd = CMD_LOAD;
            if ($urandom_range(0, 3) != 0) pos = POS_W'($urandom_range(0, NLEN - 1));
         end else if (pick < 98) begin
            cmd = CMD_SAVE;
         end else begin
            cmd = CMD_UNUSED;
         end
         send_command(cmd, key, pos, 8'($urandom));
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_cmd        = CMD_TICK;
      req_key        = '0;
      req_position   = '0;
      req_load_value = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      foreach (name_buf[i]) name_buf[i] = SPACE_CHAR;
      cursor_m     = 0;
      countdown_m  = '0;
      timeout_m    = TAP_TIMEOUT_RESET;
      prev_key_m   = '0;
      group_base_m = '0;
      group_size_m = 0;
      group_off_m  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_multitap();
      test_editing();
      test_zero_timeout();
      test_random_editing(26, 8'd1);
      test_random_editing(26, 8'd255);
      test_random_editing(26, 8'($urandom_range(2, 8)));
      test_random_editing(26, 8'd3);

      drain();
      if (fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
sv/mne_pkg.sv
sv/mne_ctrl.sv
sv/mne_datapath.sv
sv/multitap_name_editor.sv
sim/multitap_name_editor_test.sv
